// File: rtl/voice_slot_audio_mixer_core_assert.svh
// ----------------------------------------------------------------------------
// voice slot mixer assertion macros
// concurrent checks with a clock, an active-low reset, a condition and a consequence
// ----------------------------------------------------------------------------
`ifndef VOICE_SLOT_AUDIO_MIXER_CORE_ASSERT_SVH
`define VOICE_SLOT_AUDIO_MIXER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define VSAM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
`define VSAM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define VSAM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VSAM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/vsam_pkg.sv
// ----------------------------------------------------------------------------
// vsam_pkg
// shared types, codes and constants of the voice slot mixer
// ----------------------------------------------------------------------------
package vsam_pkg;

    localparam int VOICE_SLOTS_DEF  = 32;
    localparam int SAMPLE_WORDS_DEF = 65536;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 17;
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 7;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 6;
    localparam int CFG_IW   = 2;

    localparam logic [VOL_W-1:0] VOL_RESET = 7'd100;
    localparam logic [VOL_W-1:0] PERCENT   = 7'd100;
    localparam logic [LEN_W-1:0] MAX_LEN   = 17'd65536;

    localparam logic [CFG_IW-1:0] CFG_VOL_ZERO   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_VOL_ONE    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_VOL_MASTER = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_MIX  = 2'd0,
        FUNC_PLAY = 2'd1,
        FUNC_STOP = 2'd2,
        FUNC_LOAD = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_BAD_ARG = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic do_exec;
        logic set_bad;
        logic scan;
        logic set_full;
        logic acc_clr;
        logic walk;
        logic div1_start;
        logic div_step;
        logic scale;
        logic mix_final;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  len_bad;
        logic  n_zero;
        logic  slot_free;
        logic  div_last;
        logic  out_free;
    } t_dp_sts;

endpackage

// File: rtl/voice_slot_audio_mixer_core.sv
// ----------------------------------------------------------------------------
// voice_slot_audio_mixer_core
// sample memory mixer with voice slots, per-channel and master volume
// ----------------------------------------------------------------------------
// One transaction at a time. Play scans the slots for a free one, one slot per
// cycle; a mix tick with active voices walks every slot, one slot read from the
// single memory read port per cycle, then the average and the master scaling
// each take one pass of a two-bit-per-cycle divider. The next transaction is
// accepted while a result waits at the output.
module voice_slot_audio_mixer_core #(
    parameter int VOICE_SLOTS  = vsam_pkg::VOICE_SLOTS_DEF,
    parameter int SAMPLE_WORDS = vsam_pkg::SAMPLE_WORDS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vsam_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [vsam_pkg::VOL_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [vsam_pkg::FUNC_W-1:0]          i_func,
    input  logic [vsam_pkg::SLOT_W-1:0]          i_slot,
    input  logic [vsam_pkg::ADDR_W-1:0]          i_start_address,
    input  logic [vsam_pkg::LEN_W-1:0]           i_track_length,
    input  logic                                 i_sink_select,
    input  logic signed [vsam_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [vsam_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic [vsam_pkg::SLOT_W-1:0]          o_slot_id,
    output logic [vsam_pkg::STAT_W-1:0]          o_status,
    output logic [vsam_pkg::CNT_W-1:0]           o_active_count
);
    import vsam_pkg::*;
    `include "voice_slot_audio_mixer_core_assert.svh"

    localparam int IW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [IW-1:0] idx;

    vsam_ctrl #(
        .VOICE_SLOTS (VOICE_SLOTS),
        .IW          (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    vsam_datapath #(
        .VOICE_SLOTS  (VOICE_SLOTS),
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .IW           (IW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_slot          (i_slot),
        .i_start_address (i_start_address),
        .i_track_length  (i_track_length),
        .i_sink_select   (i_sink_select),
        .i_sample_value  (i_sample_value),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_mixed_sample  (o_mixed_sample),
        .o_slot_id       (o_slot_id),
        .o_status        (o_status),
        .o_active_count  (o_active_count)
    );

    `VSAM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `VSAM_ASSERT_IMP(a_full_no_slot, i_clk, i_rst_n, o_out_valid && o_status == ST_NO_SLOT, o_slot_id == '0)
    `VSAM_ASSERT_IMP(a_mix_status_ok, i_clk, i_rst_n, o_out_valid && o_mixed_sample != '0, o_status == ST_OK)

endmodule

// File: rtl/vsam_ctrl.sv
// ----------------------------------------------------------------------------
// vsam_ctrl
// sequencer: operation dispatch, slot walk and divider passes
// ----------------------------------------------------------------------------
module vsam_ctrl #(
    parameter int VOICE_SLOTS = vsam_pkg::VOICE_SLOTS_DEF,
    parameter int IW          = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vsam_pkg::t_dp_sts i_sts,
    output vsam_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]     o_idx
);
    import vsam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SCAN, S_WALK, S_DRAIN, S_DIVLD,
        S_DIV1, S_SCALE, S_DIV2, S_FIN, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx;
    logic          idx_last;

    assign idx_last   = (r_idx == IW'(VOICE_SLOTS - 1));
    assign o_idx      = r_idx;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.func)
                    FUNC_MIX: begin
                        if (i_sts.n_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.acc_clr = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    FUNC_PLAY: begin
                        if (i_sts.len_bad) begin
                            o_cmd.set_bad = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.do_exec = 1'b1;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.slot_free) begin
                    n_state = S_DONE;
                end else if (idx_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (idx_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DIVLD;
            S_DIVLD: begin
                o_cmd.div1_start = 1'b1;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.mix_final = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_idx <= '0;
            end else if ((r_state == S_SCAN || r_state == S_WALK) && !idx_last) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

// File: rtl/vsam_datapath.sv
// ----------------------------------------------------------------------------
// vsam_datapath
// sample memory, slot registers, accumulator, shared divider, output register
// ----------------------------------------------------------------------------
module vsam_datapath #(
    parameter int VOICE_SLOTS  = vsam_pkg::VOICE_SLOTS_DEF,
    parameter int SAMPLE_WORDS = vsam_pkg::SAMPLE_WORDS_DEF,
    parameter int IW           = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vsam_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [vsam_pkg::VOL_W-1:0]          i_cfg_data,
    input  logic [vsam_pkg::FUNC_W-1:0]         i_func,
    input  logic [vsam_pkg::SLOT_W-1:0]         i_slot,
    input  logic [vsam_pkg::ADDR_W-1:0]         i_start_address,
    input  logic [vsam_pkg::LEN_W-1:0]          i_track_length,
    input  logic                                i_sink_select,
    input  logic signed [vsam_pkg::SAMPLE_W-1:0] i_sample_value,
    input  vsam_pkg::t_dp_cmd                   i_cmd,
    input  logic [IW-1:0]                       i_idx,
    output vsam_pkg::t_dp_sts                   o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [vsam_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic [vsam_pkg::SLOT_W-1:0]         o_slot_id,
    output logic [vsam_pkg::STAT_W-1:0]         o_status,
    output logic [vsam_pkg::CNT_W-1:0]          o_active_count
);
    import vsam_pkg::*;

    localparam int AW     = $clog2(SAMPLE_WORDS);
    localparam int CW     = $clog2(VOICE_SLOTS + 1);
    localparam int ACC_W  = 23 + CW;
    localparam int QW     = ((ACC_W + 1) / 2) * 2;
    localparam int DV_W   = VOL_W + CW;
    localparam int DSTEPS = QW / 2;
    localparam int DCW    = $clog2(DSTEPS + 1);

    logic signed [SAMPLE_W-1:0] r_mem [SAMPLE_WORDS];
    logic signed [SAMPLE_W-1:0] r_mem_q;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;

    logic [VOICE_SLOTS-1:0] r_act;
    logic [LEN_W-1:0]       r_pos  [VOICE_SLOTS];
    logic [LEN_W-1:0]       r_end  [VOICE_SLOTS];
    logic                   r_sink [VOICE_SLOTS];
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_n;

    logic [VOL_W-1:0] r_vol0, r_vol1, r_volm;

    t_func                r_func;
    logic [SLOT_W-1:0]    r_slot;
    logic [ADDR_W-1:0]    r_start;
    logic [LEN_W-1:0]     r_len;
    logic                 r_sink_in;
    logic signed [SAMPLE_W-1:0] r_value;

    logic                 r_rd_valid;
    logic [VOL_W-1:0]     r_rd_vol;
    logic signed [ACC_W-1:0] r_acc;

    logic [QW-1:0]        r_dq;
    logic [DV_W:0]        r_rem;
    logic [DV_W-1:0]      r_div;
    logic                 r_neg;
    logic [DCW-1:0]       r_dcnt;

    logic signed [SAMPLE_W-1:0] r_res_mixed;
    logic [SLOT_W-1:0]    r_res_slot;
    t_status              r_res_status;

    logic                 r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_mixed;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [STAT_W-1:0]    r_out_status;
    logic [CNT_W-1:0]     r_out_cnt;

    logic [LEN_W-1:0]     n_pos;
    logic [QW-1:0]        n_dq;
    logic [DV_W:0]        n_rem;
    logic [ACC_W-1:0]     acc_mag;
    logic signed [SAMPLE_W-1:0] avg;
    logic signed [23:0]   prod;
    logic [23:0]          prod_mag;
    logic [6:0]           stop_ext;
    logic [IW-1:0]        stop_idx;
    logic                 stop_bad;

    function automatic logic signed [SAMPLE_W-1:0] clamp_mag(input logic neg,
                                                              input logic [QW-1:0] q);
        logic signed [SAMPLE_W-1:0] res;
        if (neg) begin
            if (q > QW'(32768)) res = -16'sd32768;
            else                res = SAMPLE_W'(-q);
        end else begin
            if (q > QW'(32767)) res = 16'sd32767;
            else                res = SAMPLE_W'(q);
        end
        return res;
    endfunction

    assign rd_addr  = AW'({12'b0, r_pos[i_idx]});
    assign wr_addr  = AW'({4'b0, r_start});
    assign n_pos    = r_pos[i_idx] + 1'b1;
    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign avg      = clamp_mag(r_neg, r_dq);
    assign prod     = avg * signed'({1'b0, r_volm});
    assign prod_mag = prod[23] ? 24'(-prod) : 24'(prod);
    assign stop_ext = {2'b0, r_slot};
    assign stop_idx = IW'(stop_ext);
    assign stop_bad = (stop_ext >= 7'(VOICE_SLOTS));

    always_comb begin
        n_dq  = r_dq;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            n_rem = {n_rem[DV_W-1:0], n_dq[QW-1]};
            n_dq  = {n_dq[QW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_div}) begin
                n_rem   = n_rem - {1'b0, r_div};
                n_dq[0] = 1'b1;
            end
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.len_bad   = (r_len == '0) || (r_len > MAX_LEN);
    assign o_sts.n_zero    = (r_cnt == '0);
    assign o_sts.slot_free = !r_act[i_idx];
    assign o_sts.div_last  = (r_dcnt == DCW'(DSTEPS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // sample memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_exec && r_func == FUNC_LOAD) r_mem[wr_addr] <= r_value;
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol0 <= VOL_RESET;
            r_vol1 <= VOL_RESET;
            r_volm <= VOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VOL_ZERO:   r_vol0 <= i_cfg_data;
                CFG_VOL_ONE:    r_vol1 <= i_cfg_data;
                CFG_VOL_MASTER: r_volm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= '0;
            r_cnt      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.walk && r_act[i_idx];
            if (i_cmd.scan && !r_act[i_idx]) begin
                r_act[i_idx] <= 1'b1;
                r_cnt        <= r_cnt + 1'b1;
            end
            if (i_cmd.walk && r_act[i_idx] && n_pos >= r_end[i_idx]) begin
                r_act[i_idx] <= 1'b0;
                r_cnt        <= r_cnt - 1'b1;
            end
            if (i_cmd.do_exec && r_func == FUNC_STOP && !stop_bad && r_act[stop_idx]) begin
                r_act[stop_idx] <= 1'b0;
                r_cnt           <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && !r_act[i_idx]) begin
            r_pos[i_idx]  <= {1'b0, r_start};
            r_end[i_idx]  <= {1'b0, r_start} + r_len;
            r_sink[i_idx] <= r_sink_in;
        end
        if (i_cmd.walk && r_act[i_idx]) r_pos[i_idx] <= n_pos;
        r_rd_vol <= r_sink[i_idx] ? r_vol1 : r_vol0;
    end

    // transaction capture, accumulation, divider and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func       <= t_func'(i_func);
            r_slot       <= i_slot;
            r_start      <= i_start_address;
            r_len        <= i_track_length;
            r_sink_in    <= i_sink_select;
            r_value      <= i_sample_value;
            r_res_mixed  <= '0;
            r_res_slot   <= '0;
            r_res_status <= ST_OK;
        end
        if (i_cmd.do_exec && r_func == FUNC_STOP && stop_bad) r_res_status <= ST_BAD_ARG;
        if (i_cmd.set_bad)  r_res_status <= ST_BAD_ARG;
        if (i_cmd.set_full) r_res_status <= ST_NO_SLOT;
        if (i_cmd.scan && !r_act[i_idx]) r_res_slot <= SLOT_W'(i_idx);

        if (i_cmd.acc_clr) begin
            r_acc <= '0;
            r_n   <= r_cnt;
        end else if (r_rd_valid) begin
            r_acc <= r_acc + ACC_W'(r_mem_q * signed'({1'b0, r_rd_vol}));
        end

        if (i_cmd.div1_start) begin
            r_neg  <= r_acc[ACC_W-1];
            r_dq   <= QW'(acc_mag);
            r_rem  <= '0;
            r_div  <= DV_W'(r_n) * DV_W'(PERCENT);
            r_dcnt <= '0;
        end else if (i_cmd.scale) begin
            r_neg  <= prod[23];
            r_dq   <= QW'(prod_mag);
            r_rem  <= '0;
            r_div  <= DV_W'(PERCENT);
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dq   <= n_dq;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + 1'b1;
        end

        if (i_cmd.mix_final) r_res_mixed <= clamp_mag(r_neg, r_dq);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_mixed  <= r_res_mixed;
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
            r_out_cnt    <= CNT_W'(r_cnt);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mixed_sample = r_out_mixed;
    assign o_slot_id      = r_out_slot;
    assign o_status       = r_out_status;
    assign o_active_count = r_out_cnt;

endmodule

// File: tb/voice_slot_audio_mixer_core_test.sv
// ----------------------------------------------------------------------------
// voice_slot_audio_mixer_core_test
// directed table then random phases of load, play, stop and mix transactions,
// each result checked against its table entry or a local prediction of the voice
// slot mixer, with bursty input, stalling output and volume changes between phases
// ----------------------------------------------------------------------------
module voice_slot_audio_mixer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vsam_pkg::*;

    typedef struct packed {
        t_func             func;
        logic [4:0]        slot;
        logic [15:0]       addr;
        logic [16:0]       len;
        logic              sink;
        logic signed [15:0] val;
    } t_req;

    typedef struct packed {
        logic signed [15:0] mixed;
        logic [4:0]         id;
        logic [1:0]         status;
        logic [5:0]         cnt;
    } t_res;

    typedef struct packed {
        t_req req;
        logic chk;
        t_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [VOL_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [FUNC_W-1:0] i_func = '0;
    logic [SLOT_W-1:0] i_slot = '0;
    logic [ADDR_W-1:0] i_start_address = '0;
    logic [LEN_W-1:0] i_track_length = '0;
    logic i_sink_select = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_value = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_mixed_sample;
    logic [SLOT_W-1:0] o_slot_id;
    logic [STAT_W-1:0] o_status;
    logic [CNT_W-1:0] o_active_count;

    voice_slot_audio_mixer_core dut (.*);

    always #2 i_clk = ~i_clk;

    // local copy of the mixer state
    logic signed [15:0] mem [0:65535];
    bit                 written [0:65535];
    bit                 act [0:31];
    logic [16:0]        pos [0:31];
    logic [16:0]        endp [0:31];
    bit                 snk [0:31];
    logic [6:0]         vol0 = 7'd100, vol1 = 7'd100, volm = 7'd100;

    t_res pending_results [$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   items_sent = 0;

    function automatic int count_active();
        int n;
        n = 0;
        for (int i = 0; i < 32; i++) if (act[i]) n++;
        return n;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_res mixer_predict(t_req r);
        t_res o;
        int n, k;
        longint acc, avg;
        o = '0;
        o.status = ST_OK;
        case (r.func)
            FUNC_MIX: begin
                n = count_active();
                if (n > 0) begin
                    acc = 0;
                    for (int i = 0; i < 32; i++) begin
                        if (act[i]) begin
                            acc += longint'(mem[pos[i][15:0]]) *
                                   longint'(snk[i] ? vol1 : vol0);
                            pos[i] = pos[i] + 17'd1;
                            if (pos[i] >= endp[i]) act[i] = 0;
                        end
                    end
                    avg = clamp16(acc / (longint'(100) * n));
                    o.mixed = 16'(clamp16((avg * longint'(volm)) / 100));
                end
            end
            FUNC_PLAY: begin
                if (r.len == 0 || r.len > MAX_LEN) begin
                    o.status = ST_BAD_ARG;
                end else begin
                    k = 32;
                    for (int i = 31; i >= 0; i--) if (!act[i]) k = i;
                    if (k == 32) begin
                        o.status = ST_NO_SLOT;
                    end else begin
                        act[k] = 1;
                        pos[k] = {1'b0, r.addr};
                        endp[k] = {1'b0, r.addr} + r.len;
                        snk[k] = r.sink;
                        o.id = 5'(k);
                    end
                end
            end
            FUNC_STOP: act[r.slot] = 0;
            default: begin
                mem[r.addr] = r.val;
                written[r.addr] = 1;
            end
        endcase
        o.cnt = 6'(count_active());
        return o;
    endfunction

    task automatic send_item(input t_req r, input logic chk, input t_res e);
        int gap;
        t_res p;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        items_sent++;
        i_in_valid <= 1'b1;
        i_func <= r.func;
        i_slot <= r.slot;
        i_start_address <= r.addr;
        i_track_length <= r.len;
        i_sink_select <= r.sink;
        i_sample_value <= r.val;
        do @(posedge i_clk); while (!o_in_ready);
        p = mixer_predict(r);
        pending_results.push_back(chk ? e : p);
        @(negedge i_clk);
    endtask

    task automatic drain_and_rest();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_volumes(input logic [6:0] v0, input logic [6:0] v1,
                                 input logic [6:0] vm);
        logic [6:0] vals [3];
        vals = '{v0, v1, vm};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_IW'(i);
            i_cfg_data <= vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        vol0 = v0;
        vol1 = v1;
        volm = vm;
    endtask

    function automatic t_req random_fields();
        t_req r;
        r.func = t_func'($urandom_range(0, 3));
        r.slot = 5'($urandom);
        r.addr = 16'($urandom);
        r.len = 17'($urandom);
        r.sink = 1'($urandom);
        r.val = 16'($urandom);
        return r;
    endfunction

    task automatic send_random();
        t_req r, f;
        int w, lsel;
        r = random_fields();
        w = $urandom_range(0, 99);
        if (w < 40) begin
            // keep every voice's next read on a written word
            for (int i = 0; i < 32; i++) begin
                if (act[i] && !written[pos[i][15:0]]) begin
                    f = random_fields();
                    f.func = FUNC_LOAD;
                    f.addr = pos[i][15:0];
                    send_item(f, 1'b0, '0);
                end
            end
            r.func = FUNC_MIX;
        end else if (w < 65) begin
            r.func = FUNC_PLAY;
            if ($urandom_range(0, 4) != 0) r.addr = 16'($urandom_range(0, 255));
            lsel = $urandom_range(0, 99);
            if (lsel < 60) r.len = 17'($urandom_range(1, 16));
            else if (lsel < 75) r.len = 17'($urandom_range(17, 400));
            else if (lsel < 80) r.len = MAX_LEN;
            else if (lsel < 85) r.len = '0;
            else if (lsel < 90) r.len = 17'($urandom_range(65537, 131071));
        end else if (w < 80) begin
            r.func = FUNC_STOP;
        end else begin
            r.func = FUNC_LOAD;
            if ($urandom_range(0, 3) != 0) r.addr = 16'($urandom_range(0, 300));
            case ($urandom_range(0, 5))
                0: r.val = 16'sh7fff;
                1: r.val = -16'sh8000;
                default: ;
            endcase
        end
        send_item(r, 1'b0, '0);
    endtask

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom);
            2: i_out_ready <= ($urandom_range(0, 9) == 0);
            default: i_out_ready <= stall_tick[0];
        endcase
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("Regression FAIL");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_mixed_sample !== e.mixed) begin
                        $error("mixed_sample expected %0d actual %0d", e.mixed, o_mixed_sample);
                        errors++;
                    end
                    if (o_slot_id !== e.id) begin
                        $error("slot_id expected %0d actual %0d", e.id, o_slot_id);
                        errors++;
                    end
                    if (o_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_status);
                        errors++;
                    end
                    if (o_active_count !== e.cnt) begin
                        $error("active_count expected %0d actual %0d", e.cnt, o_active_count);
                        errors++;
                    end
                end
            end
        end
    end

    t_row dir [$];

    initial begin
        int phase_end;
        for (int i = 0; i < 32; i++) begin
            act[i] = 0;
            pos[i] = '0;
            endp[i] = '0;
            snk[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir.push_back('{'{FUNC_MIX, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_STOP, 5'd5, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_PLAY, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_BAD_ARG, 6'd0}});
        dir.push_back('{'{FUNC_PLAY, 5'd0, 16'd0, 17'd65537, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_BAD_ARG, 6'd0}});
        dir.push_back('{'{FUNC_PLAY, 5'd31, 16'hffff, 17'h1ffff, 1'b1, -16'sd1}, 1'b1,
                        '{16'sd0, 5'd0, ST_BAD_ARG, 6'd0}});
        dir.push_back('{'{FUNC_LOAD, 5'd0, 16'd0, 17'd0, 1'b0, 16'sh7fff}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_LOAD, 5'd31, 16'hffff, 17'h1ffff, 1'b1, -16'sh8000}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_LOAD, 5'd0, 16'd1, 17'd0, 1'b0, -16'sd1}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_PLAY, 5'd0, 16'd0, 17'd1, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd1}});
        dir.push_back('{'{FUNC_MIX, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sh7fff, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_PLAY, 5'd0, 16'hffff, 17'd2, 1'b1, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd1}});
        dir.push_back('{'{FUNC_MIX, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{-16'sh8000, 5'd0, ST_OK, 6'd1}});
        dir.push_back('{'{FUNC_MIX, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sh7fff, 5'd0, ST_OK, 6'd0}});
        dir.push_back('{'{FUNC_PLAY, 5'd0, 16'd1, MAX_LEN, 1'b1, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd1}});
        dir.push_back('{'{FUNC_MIX, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{-16'sd1, 5'd0, ST_OK, 6'd1}});
        dir.push_back('{'{FUNC_PLAY, 5'd0, 16'hffff, MAX_LEN, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd1, ST_OK, 6'd2}});
        dir.push_back('{'{FUNC_LOAD, 5'd0, 16'd2, 17'd0, 1'b0, 16'sd3}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd2}});
        dir.push_back('{'{FUNC_MIX, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b0, '0});
        dir.push_back('{'{FUNC_STOP, 5'd31, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd2}});
        dir.push_back('{'{FUNC_STOP, 5'd0, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd1}});
        dir.push_back('{'{FUNC_STOP, 5'd1, 16'd0, 17'd0, 1'b0, 16'sd0}, 1'b1,
                        '{16'sd0, 5'd0, ST_OK, 6'd0}});
        foreach (dir[i]) send_item(dir[i].req, dir[i].chk, dir[i].res);

        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                drain_and_rest();
                if (p == 1) write_volumes(7'd0, 7'd0, 7'd0);
                else if (p == 2) write_volumes(7'd127, 7'd127, 7'd127);
                else if (p == 3) write_volumes(7'd100, 7'd0, 7'd127);
                else write_volumes(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                   7'($urandom_range(0, 127)));
            end
            phase_end = items_sent + 125;
            while (items_sent < phase_end) send_random();
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
